/* rtl/double_ended_queue_unit_macros.svh */
// ---------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent assertion wrappers shared by the queue unit. DEQ_ASSERT takes a
// label, a clock, an active-low reset, a property and a message; the property
// is not checked while the reset is asserted. DEQ_ASSERT_ALWAYS takes the same
// arguments without the reset and is checked at every clock edge.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DEQ_ASSERT(lbl, clk, rstn, prop, msg)

`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/deq_pkg.sv */
// ---------------------------------------------------------------------------
// Double-ended queue package
// Sizes, codes and transfer types shared by the queue cells and the top level.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD       = 2'd0,
    MODE_LOAD       = 2'd1,
    MODE_TAKE_LEFT  = 2'd2,
    MODE_TAKE_RIGHT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       tap_sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [4:0]  occupancy;
    logic        empty_flag;
  } out_item_t;

endpackage

/* rtl/deq_cell.sv */
// ---------------------------------------------------------------------------
// Double-ended queue cell
// Holds one queued word and loads it from the push word or a neighbor.
// ---------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  word_t      left_word,
  input  word_t      right_word,
  input  word_t      push_word,
  output word_t      word,
  output word_t      tap
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    case (ctrl.mode)
      MODE_LOAD:       word_nxt = push_word;
      MODE_TAKE_LEFT:  word_nxt = left_word;
      MODE_TAKE_RIGHT: word_nxt = right_word;
      default:         word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  assign tap  = ctrl.tap_sel ? word_r : '0;

endmodule

/* rtl/double_ended_queue_unit.sv */
// ---------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque built as a row of word cells with the front word in cell zero.
// ---------------------------------------------------------------------------
// The unit takes one transfer per clock cycle and returns its result from an
// output register; while that register holds a stalled result, in_stall is
// high. Pushing at the front shifts the whole cell row by one place toward the
// back in that cycle, popping at the front shifts it toward the front, and back
// operations touch only the cell selected by the word count.
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "double_ended_queue_unit_macros.svh"

  count_t     count_r;
  count_t     count_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;

  cell_ctrl_t ctrl [DEPTH];
  word_t      cell_word [DEPTH];
  word_t      cell_tap [DEPTH];
  word_t      push_word;
  word_t      back_word;
  word_t      rd_word;
  status_t    status;
  logic       in_fire;
  logic       is_full;
  logic       is_empty;
  logic       do_push_front;
  logic       do_push_back;
  logic       do_pop_front;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign push_word = DATA_WIDTH'(in_data.data_in);
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    rd_word       = '0;
    status        = ST_OK;
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    case (in_data.opcode)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          do_push_front = in_fire;
          count_nxt     = count_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          do_push_back = in_fire;
          count_nxt    = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          do_pop_front = in_fire;
          rd_word      = cell_word[0];
          count_nxt    = count_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          rd_word   = back_word;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          rd_word = cell_word[0];
        end
      end
      OP_PEEK_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          rd_word = back_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].tap_sel = (count_r == CNT_W'(i + 1));
      if (do_push_front) begin
        ctrl[i].mode = (i == 0) ? MODE_LOAD : MODE_TAKE_LEFT;
      end else if (do_pop_front) begin
        ctrl[i].mode = MODE_TAKE_RIGHT;
      end else if (do_push_back && (count_r == CNT_W'(i))) begin
        ctrl[i].mode = MODE_LOAD;
      end else begin
        ctrl[i].mode = MODE_HOLD;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_word;
    word_t right_word;

    if (g == 0) begin : g_first
      assign left_word = push_word;
    end else begin : g_inner_left
      assign left_word = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_right
      assign right_word = cell_word[g+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .left_word  (left_word),
      .right_word (right_word),
      .push_word  (push_word),
      .word       (cell_word[g]),
      .tap        (cell_tap[g])
    );
  end

  always_comb begin
    out_data_nxt.data_out   = 32'(rd_word);
    out_data_nxt.status     = status;
    out_data_nxt.occupancy  = 5'(count_nxt);
    out_data_nxt.empty_flag = (count_nxt == '0);
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DEQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "word count above depth")
  `DEQ_ASSERT(a_push_counts, clk, rst_n, (rst_n && in_fire && !is_full && (in_data.opcode == OP_PUSH_FRONT || in_data.opcode == OP_PUSH_BACK)) |=> (count_r == $past(count_r) + 1'b1), "successful push did not raise the count")
  `DEQ_ASSERT(a_empty_flag, clk, rst_n, out_valid_r |-> (out_data_r.empty_flag == (out_data_r.occupancy == '0)), "empty flag disagrees with occupancy")
  `DEQ_ASSERT(a_error_zero, clk, rst_n, (out_valid_r && out_data_r.status != ST_OK) |-> (out_data_r.data_out == '0), "error result carries data")

endmodule
